// ----- rtl/tile_neighbour_autotile_code_unit_assert.svh -----
// assertion macros shared by the checker
`ifndef TILE_NEIGHBOUR_AUTOTILE_CODE_UNIT_ASSERT_SVH
`define TILE_NEIGHBOUR_AUTOTILE_CODE_UNIT_ASSERT_SVH

// clocked on clk, disabled while rst is high
`define TNAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked on clk, also checked during reset
`define TNAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/tnac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_pkg
// Types and constants shared by the autotile code unit: action codes,
// microcode word layout, sequencer states and neighbour offsets.
// ----------------------------------------------------------------------------
package tnac_pkg;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam int         NUM_SLOTS = 12;
  localparam logic [3:0] SLOT_C    = 4'd12;

  typedef logic [4:0] step_t;

  localparam step_t ST_READ_C = 5'd3;
  localparam step_t ST_NBR0   = 5'd4;
  localparam step_t ST_FIN    = 5'd17;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_READ,
    MOP_WRITE
  } mop_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_OUTSIDE,
    JMP_QUERY,
    JMP_EMPTY
  } jmp_t;

  typedef struct packed {
    mop_t       mop;
    logic [3:0] slot;
    jmp_t       jmp;
    step_t      target;
    logic       fin;
  } uword_t;

  localparam uword_t UW_NOP = '{
    mop:    MOP_NONE,
    slot:   4'd0,
    jmp:    JMP_NONE,
    target: 5'd0,
    fin:    1'b0
  };

  typedef struct packed {
    logic   clear;
    logic   load;
    uword_t uw;
  } dp_ctl_t;

  typedef struct packed {
    logic clr_done;
    logic outside;
    logic query;
    logic empty;
  } dp_stat_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // up, left, right, down, four diagonals, four at distance two; center otherwise
  function automatic logic signed [2:0] nbr_dx(input logic [3:0] slot);
    logic signed [2:0] d;
    case (slot)
      4'd1, 4'd4, 4'd6:  d = -3'sd1;
      4'd2, 4'd5, 4'd7:  d = 3'sd1;
      4'd9:              d = -3'sd2;
      4'd10:             d = 3'sd2;
      default:           d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] nbr_dy(input logic [3:0] slot);
    logic signed [2:0] d;
    case (slot)
      4'd0, 4'd4, 4'd5:  d = 3'sd1;
      4'd3, 4'd6, 4'd7:  d = -3'sd1;
      4'd8:              d = 3'sd2;
      4'd11:             d = -3'sd2;
      default:           d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/tnac_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tnac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tnac_urom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_urom
// Microcode store: one control word per step of the item program.
// ----------------------------------------------------------------------------
module tnac_urom (
  input  tnac_pkg::step_t  step,
  output tnac_pkg::uword_t uw
);
  import tnac_pkg::*;

  function automatic uword_t mk(input mop_t m, input logic [3:0] s, input jmp_t j,
                                input step_t t, input logic f);
    uword_t w;
    w.mop    = m;
    w.slot   = s;
    w.jmp    = j;
    w.target = t;
    w.fin    = f;
    return w;
  endfunction

  always_comb begin
    unique case (step)
      5'd0:    uw = mk(MOP_NONE,  4'd0,   JMP_OUTSIDE, ST_FIN,    1'b0);
      5'd1:    uw = mk(MOP_NONE,  4'd0,   JMP_QUERY,   ST_READ_C, 1'b0);
      5'd2:    uw = mk(MOP_WRITE, SLOT_C, JMP_ALWAYS,  ST_NBR0,   1'b0);
      5'd3:    uw = mk(MOP_READ,  SLOT_C, JMP_NONE,    5'd0,      1'b0);
      5'd4:    uw = mk(MOP_READ,  4'd0,   JMP_NONE,    5'd0,      1'b0);
      5'd5:    uw = mk(MOP_READ,  4'd1,   JMP_EMPTY,   ST_FIN,    1'b0);
      5'd6:    uw = mk(MOP_READ,  4'd2,   JMP_NONE,    5'd0,      1'b0);
      5'd7:    uw = mk(MOP_READ,  4'd3,   JMP_NONE,    5'd0,      1'b0);
      5'd8:    uw = mk(MOP_READ,  4'd4,   JMP_NONE,    5'd0,      1'b0);
      5'd9:    uw = mk(MOP_READ,  4'd5,   JMP_NONE,    5'd0,      1'b0);
      5'd10:   uw = mk(MOP_READ,  4'd6,   JMP_NONE,    5'd0,      1'b0);
      5'd11:   uw = mk(MOP_READ,  4'd7,   JMP_NONE,    5'd0,      1'b0);
      5'd12:   uw = mk(MOP_READ,  4'd8,   JMP_NONE,    5'd0,      1'b0);
      5'd13:   uw = mk(MOP_READ,  4'd9,   JMP_NONE,    5'd0,      1'b0);
      5'd14:   uw = mk(MOP_READ,  4'd10,  JMP_NONE,    5'd0,      1'b0);
      5'd15:   uw = mk(MOP_READ,  4'd11,  JMP_NONE,    5'd0,      1'b0);
      5'd16:   uw = mk(MOP_NONE,  4'd0,   JMP_NONE,    5'd0,      1'b0);
      5'd17:   uw = mk(MOP_NONE,  4'd0,   JMP_NONE,    5'd0,      1'b1);
      default: uw = mk(MOP_NONE,  4'd0,   JMP_ALWAYS,  ST_FIN,    1'b0);
    endcase
  end

endmodule

// ----- rtl/tnac_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_seq
// Sequencer: clear sweep after reset, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module tnac_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output tnac_pkg::step_t    step,
  input  tnac_pkg::uword_t   uw,
  input  tnac_pkg::dp_stat_t stat,
  output tnac_pkg::dp_ctl_t  ctl
);
  import tnac_pkg::*;

  seq_state_t state, state_next;
  step_t      step_next;
  logic       taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    case (uw.jmp)
      JMP_ALWAYS:  taken = 1'b1;
      JMP_OUTSIDE: taken = stat.outside;
      JMP_QUERY:   taken = stat.query;
      JMP_EMPTY:   taken = stat.empty;
      default:     taken = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = '0;
    unique case (state)
      SEQ_CLEAR: begin
        if (stat.clr_done) begin
          state_next = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (uw.fin) begin
          state_next = SEQ_IDLE;
        end else if (taken) begin
          step_next = uw.target;
        end else begin
          step_next = step + 5'd1;
        end
      end
      default: state_next = SEQ_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b1;
    ctl.clear = 1'b0;
    ctl.load  = 1'b0;
    ctl.uw    = UW_NOP;
    unique case (state)
      SEQ_CLEAR: ctl.clear = 1'b1;
      SEQ_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      SEQ_RUN:  ctl.uw = uw;
      default:  ctl.uw = UW_NOP;
    endcase
  end

endmodule

// ----- rtl/tnac_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_dp
// Datapath: item registers, neighbour address, map port, mask and result.
// ----------------------------------------------------------------------------
module tnac_dp #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32,
  parameter int ADDR_W = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  tnac_pkg::dp_ctl_t  ctl,
  output tnac_pkg::dp_stat_t stat,
  input  logic [1:0]         action,
  input  logic signed [6:0]  tile_x,
  input  logic signed [6:0]  tile_y,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_addr,
  output logic [0:0]         mem_wdata,
  input  logic [0:0]         mem_rdata,
  output logic               done,
  output logic               in_grid,
  output logic               filled,
  output logic [4:0]         tile_code
);
  import tnac_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;

  logic [1:0]            act;
  logic signed [6:0]     px, py;
  logic                  center;
  logic [NUM_SLOTS-1:0]  mask;
  logic                  pend_valid, pend_oob;
  logic [3:0]            pend_slot;
  logic [ADDR_W-1:0]     clr_addr;
  logic signed [2:0]     dx, dy;
  logic [7:0]            nx, ny;
  logic                  n_in, c_in, cap_bit, set_bit, hit;
  logic [4:0]            code;

  function automatic logic [4:0] code_of(input logic [NUM_SLOTS-1:0] m);
    logic [4:0] c;
    c = {1'b0, m[3:0]};
    if (m[3:0] == 4'hF) begin
      case (m[7:4])
        4'b1110: c = 5'd16;
        4'b1101: c = 5'd17;
        4'b1011: c = 5'd18;
        4'b0111: c = 5'd19;
        4'b1111: c = (m[11:8] == 4'hF) ? 5'd20 : 5'd15;
        default: c = 5'd15;
      endcase
    end
    return c;
  endfunction

  assign dx      = nbr_dx(ctl.uw.slot);
  assign dy      = nbr_dy(ctl.uw.slot);
  assign nx      = {px[6], px} + {{5{dx[2]}}, dx};
  assign ny      = {py[6], py} + {{5{dy[2]}}, dy};
  assign n_in    = !nx[7] && (nx[6:0] < 7'(GRID_W)) && !ny[7] && (ny[6:0] < 7'(GRID_H));
  assign c_in    = !px[6] && (px[6:0] < 7'(GRID_W)) && !py[6] && (py[6:0] < 7'(GRID_H));
  assign set_bit = (act == ACT_SET);
  assign cap_bit = pend_oob | mem_rdata[0];
  assign hit     = c_in & center;
  assign code    = hit ? code_of(mask) : 5'd0;

  assign stat.clr_done = ctl.clear && (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.outside  = !c_in;
  assign stat.query    = act[1];
  assign stat.empty    = !center;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ADDR_W'(ny[6:0]) * ADDR_W'(GRID_W) + ADDR_W'(nx[6:0]);
    mem_wdata = set_bit;
    if (ctl.clear) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = 1'b0;
    end else if (ctl.uw.mop == MOP_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (ctl.clear) begin
        clr_addr <= stat.clr_done ? '0 : clr_addr + 1'b1;
      end
      pend_valid <= (ctl.uw.mop == MOP_READ);
      done       <= ctl.uw.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act    <= action;
      px     <= tile_x;
      py     <= tile_y;
      center <= 1'b0;
      mask   <= '0;
    end else begin
      if (ctl.uw.mop == MOP_WRITE) begin
        center <= set_bit;
      end
      if (pend_valid) begin
        if (pend_slot == SLOT_C) begin
          center <= cap_bit;
        end else begin
          mask[pend_slot] <= cap_bit;
        end
      end
    end
    pend_slot <= ctl.uw.slot;
    pend_oob  <= !n_in;
    if (ctl.uw.fin) begin
      in_grid   <= c_in;
      filled    <= hit;
      tile_code <= code;
    end
  end

endmodule

// ----- rtl/tile_neighbour_autotile_code_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_neighbour_autotile_code_unit
// Occupancy map of a tile grid with set, clear and query of one cell and
// the cell's bitmask autotile code from twelve neighbours.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive action, tile_x, tile_y and raise start; the
//   transaction is taken at the edge where start is high and busy is low.
//   Result channel: done is high for one cycle with in_grid, filled and
//   tile_code; the receiver cannot hold it off and it is never repeated.
// Program
//   cell outside the grid: straight to the result, no map access
//   clear, or query of an empty cell: ends once the cell is seen empty
//   set, or query of a filled cell: reads all twelve neighbours
//   The map sits in one single-port RAM; the program writes the cell on set
//   or clear or reads it on query, then reads neighbours one per cycle. A new
//   command is taken in the cycle in which done is high, so items never overlap.
// Reset
//   rst is synchronous. After it the map is swept clear, one cell a cycle,
//   all GRID_W*GRID_H cells, with busy high; then busy falls.
// ----------------------------------------------------------------------------
module tile_neighbour_autotile_code_unit #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action,
  input  logic signed [6:0] tile_x,
  input  logic signed [6:0] tile_y,
  output logic              done,
  output logic              in_grid,
  output logic              filled,
  output logic [4:0]        tile_code
);
  import tnac_pkg::*;

  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(DEPTH);

  step_t             step;
  uword_t            uw;
  dp_ctl_t           ctl;
  dp_stat_t          stat;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [0:0]        mem_wdata, mem_rdata;

  tnac_urom u_urom (
    .step (step),
    .uw   (uw)
  );

  tnac_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .step  (step),
    .uw    (uw),
    .stat  (stat),
    .ctl   (ctl)
  );

  tnac_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H),
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .action    (action),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .done      (done),
    .in_grid   (in_grid),
    .filled    (filled),
    .tile_code (tile_code)
  );

  tnac_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/tnac_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnac_checker
// Port-level checks on the autotile code unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "tile_neighbour_autotile_code_unit_assert.svh"

module tnac_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              in_grid,
  input logic              filled,
  input logic [4:0]        tile_code
);

  // an accepted transaction raises busy
  `TNAC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")

  // a result only closes a busy period and is a strobe that is never held
  `TNAC_ASSERT(a_done_after_busy, done |-> (!busy && $past(busy)), "result outside a busy period")
  `TNAC_ASSERT(a_done_pulse, done |=> !done, "result strobe held")

  // outside cells report empty, filled cells are inside, codes stay in range
  `TNAC_ASSERT(a_result_sane, done |-> ((in_grid || (!filled && tile_code == 5'd0))
    && (filled || tile_code == 5'd0) && tile_code <= 5'd20), "inconsistent result")

  // reset leaves no stray result
  `TNAC_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "result right after reset")

endmodule

bind tile_neighbour_autotile_code_unit tnac_checker u_tnac_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the autotile code unit. A clocked driver issues
// set, clear, query and unused-action transactions from a queue. A shadow occupancy map
// predicts in_grid, filled and tile_code for each accepted transaction, and a
// clocked monitor compares each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import tnac_pkg::*;

  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [4:0] CODE_DIAG_BASE = 5'd16;
  localparam logic [4:0] CODE_SURROUNDED = 5'd20;

  typedef struct {
    logic [1:0]        act;
    logic signed [6:0] x;
    logic signed [6:0] y;
    int                idle_pct;
  } tile_cmd_t;

  typedef struct packed {
    logic       in_grid;
    logic       filled;
    logic [4:0] code;
  } tile_result_t;

  logic              clk;
  logic              rst;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action = ACT_QUERY;
  logic signed [6:0] tile_x = '0;
  logic signed [6:0] tile_y = '0;
  logic              done;
  logic              in_grid;
  logic              filled;
  logic [4:0]        tile_code;

  tile_cmd_t    pending_cmds[$];
  tile_result_t expected_tiles[$];
  logic         shadow_map[GRID_W * GRID_H];
  int           mismatches = 0;
  int           idle_cycles = 0;

  // neighbour offsets: up, left, right, down, four diagonals, four at distance two
  const int nbr_dx[12] = '{0, -1, 1, 0, -1, 1, -1, 1, 0, -2, 2, 0};
  const int nbr_dy[12] = '{1, 0, 0, -1, 1, 1, -1, -1, 2, 0, 0, -2};

  tile_neighbour_autotile_code_unit #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .tile_x   (tile_x),
    .tile_y   (tile_y),
    .done     (done),
    .in_grid  (in_grid),
    .filled   (filled),
    .tile_code(tile_code)
  );

  function automatic logic on_grid(int x, int y);
    return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
  endfunction

  // cells beyond the border count as filled
  function automatic logic cell_full(int x, int y);
    if (!on_grid(x, y)) return 1'b1;
    return shadow_map[y * GRID_W + x];
  endfunction

  function automatic logic [4:0] autotile_code(int x, int y);
    logic [11:0] mask;
    int          near_cnt;
    int          far_cnt;
    int          empty_slot;
    mask = '0;
    near_cnt = 0;
    far_cnt = 0;
    empty_slot = 0;
    for (int s = 0; s < 12; s++) begin
      if (cell_full(x + nbr_dx[s], y + nbr_dy[s])) begin
        mask[s] = 1'b1;
        if (s < 8) near_cnt++;
        else far_cnt++;
      end else if (s < 8) begin
        empty_slot = s;
      end
    end
    if (near_cnt == 7 && empty_slot >= 4) return CODE_DIAG_BASE + 5'(empty_slot - 4);
    if (near_cnt == 8 && far_cnt == 4) return CODE_SURROUNDED;
    return {1'b0, mask[3:0]};
  endfunction

  function automatic tile_result_t apply_tile_cmd(logic [1:0] act, logic signed [6:0] tx,
                                                  logic signed [6:0] ty);
    tile_result_t r;
    int           x;
    int           y;
    x = tx;
    y = ty;
    r = '0;
    if (on_grid(x, y)) begin
      if (act == ACT_SET) shadow_map[y * GRID_W + x] = 1'b1;
      else if (act == ACT_CLEAR) shadow_map[y * GRID_W + x] = 1'b0;
      r.in_grid = 1'b1;
      r.filled = shadow_map[y * GRID_W + x];
      if (r.filled) r.code = autotile_code(x, y);
    end
    return r;
  endfunction

  task automatic add_cmd(logic [1:0] act, int x, int y, int pct);
    tile_cmd_t c;
    c.act = act;
    c.x = 7'(x);
    c.y = 7'(y);
    c.idle_pct = pct;
    pending_cmds.push_back(c);
  endtask

  function automatic int pick_coord(int base);
    int s;
    s = $urandom_range(99);
    if (s < 70) return base + int'($urandom_range(5));
    if (s < 85) return int'($urandom_range(35)) - 2;
    return int'($urandom_range(127)) - 64;
  endfunction

  // mostly dense edits inside small windows so that full neighbourhoods occur
  task automatic add_random_cmds(int n, int pct);
    int          r;
    int          w;
    logic [1:0]  act;
    const int    win_x[5] = '{0, 26, 0, 26, 13};
    const int    win_y[5] = '{0, 26, 26, 0, 13};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) act = ACT_SET;
      else if (r < 62) act = ACT_CLEAR;
      else if (r < 95) act = ACT_QUERY;
      else act = ACT_UNUSED;
      w = $urandom_range(4);
      add_cmd(act, pick_coord(win_x[w]), pick_coord(win_y[w]), pct);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    logic taken;
    logic hold;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_tiles.push_back(apply_tile_cmd(action, tile_x, tile_y));
        void'(pending_cmds.pop_front());
      end
      hold = start && !taken;
      if (!hold) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
          start <= 1'b1;
          action <= pending_cmds[0].act;
          tile_x <= pending_cmds[0].x;
          tile_y <= pending_cmds[0].y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tile_result_t got;
    tile_result_t want;
    if (!rst && done) begin
      got = '{in_grid: in_grid, filled: filled, code: tile_code};
      if (expected_tiles.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: in_grid=%0b filled=%0b code=%0d",
                   got.in_grid, got.filled, got.code);
      end else begin
        want = expected_tiles.pop_front();
        if (got.in_grid !== want.in_grid || got.filled !== want.filled ||
            got.code !== want.code) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp in_grid=%0b filled=%0b code=%0d, got in_grid=%0b filled=%0b code=%0d",
                     want.in_grid, want.filled, want.code, got.in_grid, got.filled, got.code);
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction or result
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && done)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;

    // outside the grid
    add_cmd(ACT_SET, -64, -64, 0);
    add_cmd(ACT_SET, 63, 63, 0);
    add_cmd(ACT_CLEAR, 32, 0, 0);
    add_cmd(ACT_QUERY, 0, 32, 0);
    add_cmd(ACT_SET, -1, 5, 0);
    // empty cell, corners, unused action
    add_cmd(ACT_QUERY, 5, 5, 0);
    add_cmd(ACT_SET, 0, 0, 0);
    add_cmd(ACT_UNUSED, 0, 0, 0);
    add_cmd(ACT_SET, 31, 31, 0);
    add_cmd(ACT_QUERY, 31, 31, 0);
    add_cmd(ACT_CLEAR, 31, 31, 0);
    // fully surrounded corner, then one empty diagonal
    add_cmd(ACT_SET, 0, 1, 0);
    add_cmd(ACT_SET, 1, 0, 0);
    add_cmd(ACT_SET, 1, 1, 0);
    add_cmd(ACT_QUERY, 0, 0, 0);
    add_cmd(ACT_SET, 0, 2, 0);
    add_cmd(ACT_SET, 2, 0, 0);
    add_cmd(ACT_QUERY, 0, 0, 0);
    add_cmd(ACT_CLEAR, 1, 1, 0);
    add_cmd(ACT_QUERY, 0, 0, 0);
    add_cmd(ACT_CLEAR, 0, 0, 0);
    add_cmd(ACT_QUERY, 0, 0, 0);

    add_random_cmds(260, 0);
    add_random_cmds(270, 77);
    add_random_cmds(270, 11);

    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || start || expected_tiles.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_tiles.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_tiles.size());
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
